>>> rtl/tdd_pkg.sv
// Package: shared constants, codes and structs for the timed task dispatcher.
`timescale 1ns / 1ps
package tdd_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int ID_W = 4;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);
	localparam int TICK_W = 16;
	localparam int DUE_W = 17;
	localparam logic [7:0] FAIL_ID = 8'hFF;
	localparam logic [TICK_W-1:0] TICK_WRAP_RST = 16'd1000;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_REGISTER   = 3'd1,
		OP_UNREGISTER = 3'd2,
		OP_READY      = 3'd3,
		OP_BLOCK      = 3'd4,
		OP_BLOCK_ALL  = 3'd5,
		OP_QUERY      = 3'd6,
		OP_SCHEDULE   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ERR  = 2'd1,
		STAT_IDLE = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic              act;
		op_t               op;
		logic [TICK_W-1:0] ivl;
		logic [TICK_W-1:0] tick;
		logic [TICK_W-1:0] wrap;
	} cell_cmd_t;

	// cell back to the controller
	typedef struct packed {
		logic hit;
		logic ready;
		logic present;
	} cell_stat_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] rid;
		logic            rdy;
		logic            run;
		logic [ID_W-1:0] nptr;
	} result_t;

endpackage

>>> rtl/tdd_if.sv
// Interfaces: request and response channels of the dispatcher.
`timescale 1ns / 1ps
interface tdd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [3:0]  task_id;
	logic [15:0] interval;

	modport source (output valid, func, task_id, interval, input ready);
	modport sink (input valid, func, task_id, interval, output ready);
endinterface

interface tdd_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] result_id;
	logic       task_is_ready;
	logic       run_task;
	logic [3:0] next_pointer;

	modport source (output valid, status, result_id, task_is_ready, run_task, next_pointer,
		input ready);
	modport sink (input valid, status, result_id, task_is_ready, run_task, next_pointer,
		output ready);
endinterface

>>> rtl/tdd_cell.sv
// Cell: one task table entry; evaluates the scan token and passes it on.
`timescale 1ns / 1ps
module tdd_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  tdd_pkg::cell_cmd_t  cmd,
	input  logic             sel_id,
	input  logic             sel_reg,
	input  logic             tok_in,
	output logic             tok_out,
	output tdd_pkg::cell_stat_t stat
);
	import tdd_pkg::*;

	logic             ready_q;
	logic             present_q;
	logic             tok_q;
	logic [DUE_W-1:0] due_q;
	logic [TICK_W-1:0] ivl_q;
	logic             hit;

	assign hit = tok_in && ready_q && ({1'b0, cmd.tick} >= due_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q   <= 1'b0;
			present_q <= 1'b0;
			tok_q     <= 1'b0;
		end else begin
			tok_q <= tok_in && !hit;
			if (cmd.act) begin
				case (cmd.op)
					OP_REGISTER: begin
						if (sel_reg) begin
							present_q <= 1'b1;
							ready_q   <= 1'b0;
						end
					end
					OP_UNREGISTER: begin
						if (sel_id) begin
							present_q <= 1'b0;
							ready_q   <= 1'b0;
						end
					end
					OP_READY: begin
						if (sel_id) ready_q <= 1'b1;
					end
					OP_BLOCK: begin
						if (sel_id) ready_q <= 1'b0;
					end
					OP_BLOCK_ALL: begin
						ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.act && cmd.op == OP_REGISTER && sel_reg) begin
			due_q <= '0;
			ivl_q <= cmd.ivl;
		end else if (cmd.act && cmd.op == OP_UNREGISTER && sel_id) begin
			ivl_q <= '0;
		end else if (hit) begin
			due_q <= {1'b0, cmd.tick} + {1'b0, ivl_q};
		end else if (tok_in && due_q >= {1'b0, cmd.wrap}) begin
			due_q <= '0;
		end
	end

	assign tok_out       = tok_q;
	assign stat.hit      = hit;
	assign stat.ready    = ready_q;
	assign stat.present  = present_q;

endmodule

>>> rtl/timed_task_dispatcher_core.sv
// Top level: task dispatcher controller with a chain of table cells.
//
//  channel  | dir  | handshake          | carries
//  req      | in   | valid/ready        | func, task_id, interval
//  rsp      | out  | valid/ready        | status, result_id, task_is_ready, run_task, next_pointer
//  cfg      | in   | cfg_we             | tick wrap value (cfg_wdata)
//
// All operations but schedule write their result into the output or skid register as
// they are accepted. Schedule passes a token down the cell chain, one cell per cycle,
// and ends when a ready task is due or the token leaves the last cell. One item is in
// work at a time; a result waits in the output register plus one skid register, so
// stalls on rsp do not block the next accept unless both are full. Reset clears the
// table flags and counters and sets the wrap value to 1000; no clearing pass.
`timescale 1ns / 1ps
module timed_task_dispatcher_core (
	input  logic        clk,
	input  logic        arst_n,
	tdd_req_if.sink     req,
	tdd_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import tdd_pkg::*;

	state_t            state_q, state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] wrap_q;
	logic [ID_W-1:0]   rr_q;
	logic              tok0_q;
	logic              o_vld_q, h_vld_q;
	result_t           o_q, h_q;

	cell_cmd_t         cmd;
	cell_stat_t        stat [TASK_SLOTS];
	logic              tok [TASK_SLOTS];
	logic              sel_id [TASK_SLOTS];
	logic              sel_reg [TASK_SLOTS];

	op_t               op;
	logic              acc, pop, known, full;
	logic              hit_any, hit_run, tok_end, scan_done, done;
	logic [ID_W-1:0]   hit_idx, hit_nxt;
	logic [TICK_W-1:0] tick_inc;
	result_t           res_imm, res_scan, res;

	assign op    = op_t'(req.func);
	assign acc   = req.valid && req.ready;
	assign pop   = rsp.valid && rsp.ready;
	assign known = {1'b0, req.task_id} < count_q;
	assign full  = count_q >= CNT_W'(TASK_SLOTS);

	assign cmd.act  = acc;
	assign cmd.op   = op;
	assign cmd.ivl  = req.interval;
	assign cmd.tick = tick_q;
	assign cmd.wrap = wrap_q;

	genvar gi;
	generate
		for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
			assign sel_id[gi]  = known && (req.task_id == ID_W'(gi));
			assign sel_reg[gi] = count_q == CNT_W'(gi);
			tdd_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.sel_id  (sel_id[gi]),
				.sel_reg (sel_reg[gi]),
				.tok_in  ((gi == 0) ? tok0_q : tok[(gi == 0) ? 0 : gi - 1]),
				.tok_out (tok[gi]),
				.stat    (stat[gi])
			);
		end
	endgenerate

	assign tok_end = tok[TASK_SLOTS-1];

	always_comb begin
		hit_any = 1'b0;
		hit_run = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (stat[i].hit) begin
				hit_any = 1'b1;
				hit_run = stat[i].present;
				hit_idx = hit_idx | ID_W'(i);
			end
		end
	end

	assign hit_nxt = (({1'b0, hit_idx} + 1'b1) == count_q) ? '0 : hit_idx + 1'b1;

	always_comb begin
		res_scan.status = hit_any ? STAT_OK : STAT_IDLE;
		res_scan.rid    = hit_any ? hit_idx : '0;
		res_scan.rdy    = 1'b0;
		res_scan.run    = hit_any && hit_run;
		res_scan.nptr   = hit_any ? hit_nxt : '0;
	end

	always_comb begin
		res_imm.status = STAT_OK;
		res_imm.rid    = '0;
		res_imm.rdy    = 1'b0;
		res_imm.run    = 1'b0;
		res_imm.nptr   = rr_q;
		case (op)
			OP_REGISTER: begin
				if (full) begin
					res_imm.status = STAT_ERR;
					res_imm.rid    = FAIL_ID[ID_W-1:0];
				end else begin
					res_imm.rid = count_q[ID_W-1:0];
				end
			end
			OP_UNREGISTER, OP_READY, OP_BLOCK: begin
				if (!known) res_imm.status = STAT_ERR;
			end
			OP_QUERY: begin
				if (known) res_imm.rdy = stat[req.task_id].ready;
				else res_imm.status = STAT_ERR;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && op == OP_SCHEDULE) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (hit_any || tok_end) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		scan_done = 1'b0;
		done      = 1'b0;
		res       = res_imm;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = !h_vld_q;
				done      = acc && op != OP_SCHEDULE;
			end
			S_SCAN: begin
				scan_done = hit_any || tok_end;
				done      = scan_done;
				res       = res_scan;
			end
			default: ;
		endcase
	end

	always_comb begin
		tick_inc = tick_q + 1'b1;
		if (tick_inc >= wrap_q) tick_inc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			tick_q  <= '0;
			wrap_q  <= TICK_WRAP_RST;
			rr_q    <= '0;
			tok0_q  <= 1'b0;
			o_vld_q <= 1'b0;
			h_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			tok0_q  <= acc && op == OP_SCHEDULE;
			if (cfg_we) wrap_q <= cfg_wdata;
			if (acc && op == OP_TICK) tick_q <= tick_inc;
			if (acc && op == OP_REGISTER && !full) count_q <= count_q + 1'b1;
			if (scan_done) rr_q <= res_scan.nptr;
			if (done) begin
				if (!o_vld_q || pop) o_vld_q <= 1'b1;
				else h_vld_q <= 1'b1;
			end else if (pop) begin
				if (h_vld_q) h_vld_q <= 1'b0;
				else o_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (!o_vld_q || pop) o_q <= res;
			else h_q <= res;
		end else if (pop && h_vld_q) begin
			o_q <= h_q;
		end
	end

	assign rsp.valid         = o_vld_q;
	assign rsp.status        = o_q.status;
	assign rsp.result_id     = o_q.rid;
	assign rsp.task_is_ready = o_q.rdy;
	assign rsp.run_task      = o_q.run;
	assign rsp.next_pointer  = o_q.nptr;

endmodule

>>> rtl/tdd_checker.sv
// Checker: port-level assertions on the dispatcher, bound to the top level.
`timescale 1ns / 1ps
module tdd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [2:0] req_func,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [3:0] rsp_result_id,
	input logic       rsp_run_task,
	input logic [3:0] rsp_next_pointer
);
	import tdd_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_result_id) && $stable(rsp_next_pointer))
		else $error("response changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_ERR
			|| rsp_status == STAT_IDLE)
		else $error("unused status code");

	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_run_task |-> rsp_status == STAT_OK)
		else $error("run_task without dispatch");

	a_idle_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_IDLE |-> rsp_next_pointer == '0
			&& rsp_result_id == '0)
		else $error("empty schedule left pointer or id set");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == OP_SCHEDULE |=> !req_ready)
		else $error("accepted during schedule scan");

endmodule

bind timed_task_dispatcher_core tdd_checker u_tdd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_func         (req.func),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_result_id    (rsp.result_id),
	.rsp_run_task     (rsp.run_task),
	.rsp_next_pointer (rsp.next_pointer)
);

>>> test/tb_top.sv
// Testbench for the timed task dispatcher: random and directed operations vs. a predictor.
`timescale 1ns / 1ps
module tb_top;
	import tdd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 150;

	class dispatch_scoreboard;
		bit               rdy_tab[TASK_SLOTS];
		bit               present_tab[TASK_SLOTS];
		logic [DUE_W-1:0] due_tab[TASK_SLOTS];
		logic [TICK_W-1:0] ivl_tab[TASK_SLOTS];
		int               n_tasks;
		logic [TICK_W-1:0] tick;
		logic [TICK_W-1:0] wrap;
		logic [ID_W-1:0]  ptr;
		result_t          expected[$];
		int               mismatches;
		int               n_checked;
		int               n_dispatch;
		int               n_idle;
		int               n_err;

		function new();
			for (int k = 0; k < TASK_SLOTS; k++) begin
				rdy_tab[k] = 1'b0;
				present_tab[k] = 1'b0;
				due_tab[k] = '0;
				ivl_tab[k] = '0;
			end
			n_tasks = 0;
			tick = '0;
			wrap = TICK_WRAP_RST;
			ptr = '0;
			mismatches = 0;
			n_checked = 0;
			n_dispatch = 0;
			n_idle = 0;
			n_err = 0;
		endfunction

		function void set_wrap(logic [TICK_W-1:0] v);
			wrap = v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_request(op_t f, logic [ID_W-1:0] id, logic [TICK_W-1:0] ivl);
			result_t r;
			bit known;
			int nxt;
			r = '0;
			r.status = STAT_OK;
			known = id < n_tasks;
			case (f)
				OP_TICK: begin
					tick = tick + 16'd1;
					if (tick >= wrap)
						tick = '0;
				end
				OP_REGISTER: begin
					if (n_tasks < TASK_SLOTS) begin
						present_tab[n_tasks] = 1'b1;
						rdy_tab[n_tasks] = 1'b0;
						due_tab[n_tasks] = '0;
						ivl_tab[n_tasks] = ivl;
						r.rid = n_tasks[ID_W-1:0];
						n_tasks++;
					end else begin
						r.status = STAT_ERR;
						r.rid = FAIL_ID[ID_W-1:0];
					end
				end
				OP_UNREGISTER: begin
					if (known) begin
						present_tab[id] = 1'b0;
						rdy_tab[id] = 1'b0;
						ivl_tab[id] = '0;
					end else
						r.status = STAT_ERR;
				end
				OP_READY, OP_BLOCK: begin
					if (known)
						rdy_tab[id] = (f == OP_READY);
					else
						r.status = STAT_ERR;
				end
				OP_BLOCK_ALL: begin
					for (int k = 0; k < n_tasks; k++)
						rdy_tab[k] = 1'b0;
				end
				OP_QUERY: begin
					if (known)
						r.rdy = rdy_tab[id];
					else
						r.status = STAT_ERR;
				end
				default: begin
					r.status = STAT_IDLE;
					ptr = '0;
					for (int k = 0; k < n_tasks; k++) begin
						nxt = (k + 1) % n_tasks;
						if (rdy_tab[k] && {1'b0, tick} >= due_tab[k]) begin
							due_tab[k] = {1'b0, tick} + {1'b0, ivl_tab[k]};
							r.run = present_tab[k];
							r.rid = k[ID_W-1:0];
							r.status = STAT_OK;
							ptr = nxt[ID_W-1:0];
							break;
						end
						if (due_tab[k] >= {1'b0, wrap})
							due_tab[k] = '0;
						ptr = nxt[ID_W-1:0];
					end
				end
			endcase
			r.nptr = ptr;
			if (r.status == STAT_ERR)
				n_err++;
			if (f == OP_SCHEDULE && r.status == STAT_OK)
				n_dispatch++;
			if (r.status == STAT_IDLE)
				n_idle++;
			expected.push_back(r);
		endfunction

		function void check_response(logic [1:0] st, logic [ID_W-1:0] rid, logic rdy, logic run,
			logic [ID_W-1:0] nptr);
			result_t e;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d id %0d rdy %0b run %0b ptr %0d",
						st, rid, rdy, run, nptr);
				return;
			end
			e = expected.pop_front();
			n_checked++;
			if (st !== e.status || rid !== e.rid || rdy !== e.rdy || run !== e.run
				|| nptr !== e.nptr) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at result %0d:", n_checked);
					$display("  expected status %0d id %0d rdy %0b run %0b ptr %0d",
						e.status, e.rid, e.rdy, e.run, e.nptr);
					$display("  got      status %0d id %0d rdy %0b run %0b ptr %0d",
						st, rid, rdy, run, nptr);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	tdd_req_if req_ch();
	tdd_rsp_if rsp_ch();

	timed_task_dispatcher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	dispatch_scoreboard sb = new();
	bit src_burst;
	bit sink_burst;
	bit rsp_hold;
	int n_sent;
	int idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// response side: random stalls, idle-free stretches and one long hold-off
	initial begin
		int stall;
		int n;
		rsp_ch.ready = 1'b0;
		n = 0;
		sink_burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (n % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = sink_burst ? 0 : $urandom_range(0, 4);
			if (rsp_hold) begin
				rsp_hold = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_response(rsp_ch.status, rsp_ch.result_id, rsp_ch.task_is_ready,
				rsp_ch.run_task, rsp_ch.next_pointer);
			n++;
		end
	end

	task automatic send_op(input op_t f, input logic [3:0] id, input logic [15:0] ivl);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.task_id <= id;
		req_ch.interval <= ivl;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(f, id, ivl);
		n_sent++;
	endtask

	task automatic write_wrap(input logic [15:0] v);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_wrap(v);
	endtask

	function automatic op_t pick_op();
		int b;
		b = $urandom_range(0, 999);
		if (b < 300) return OP_TICK;
		if (b < 550) return OP_SCHEDULE;
		if (b < 700) return OP_READY;
		if (b < 760) return OP_BLOCK;
		if (b < 775) return OP_BLOCK_ALL;
		if (b < 782) return OP_UNREGISTER;
		if (b < 860) return OP_QUERY;
		return OP_REGISTER;
	endfunction

	function automatic logic [3:0] pick_id();
		if (sb.n_tasks > 0 && $urandom_range(0, 99) < 85)
			return 4'($urandom_range(0, sb.n_tasks - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [15:0] pick_interval();
		int b;
		logic [31:0] w;
		b = $urandom_range(0, 9);
		w = $urandom;
		if (b < 4) return 16'($urandom_range(0, 12));
		if (b == 4) return 16'h0000;
		if (b == 5) return 16'hFFFF;
		if (b < 8) return 16'($urandom_range(0, 300));
		return w[15:0];
	endfunction

	initial begin
		logic [15:0] wraps[7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.task_id = '0;
		req_ch.interval = '0;
		rsp_hold = 1'b0;
		src_burst = 1'b0;
		n_sent = 0;
		idle_cycles = 0;
		wraps[0] = 16'd1000;
		wraps[1] = 16'd50;
		wraps[2] = 16'hFFFF;
		wraps[3] = 16'd1;
		wraps[4] = 16'd0;
		wraps[5] = 16'($urandom_range(2, 400));
		wraps[6] = 16'd1000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unknown id, dispatch, stale due reset,
		// dispatch of a readied unregistered task, block all
		send_op(OP_SCHEDULE, 4'd0, 16'h0000);
		send_op(OP_QUERY, 4'd3, 16'h0000);
		send_op(OP_TICK, 4'd15, 16'hFFFF);
		send_op(OP_REGISTER, 4'd0, 16'h0000);
		send_op(OP_REGISTER, 4'd0, 16'hFFFF);
		send_op(OP_READY, 4'd0, 16'h0000);
		send_op(OP_READY, 4'd1, 16'h0000);
		send_op(OP_QUERY, 4'd1, 16'h0000);
		send_op(OP_SCHEDULE, 4'd0, 16'h0000);
		send_op(OP_BLOCK, 4'd0, 16'h0000);
		send_op(OP_SCHEDULE, 4'd0, 16'h0000);
		send_op(OP_UNREGISTER, 4'd1, 16'h0000);
		send_op(OP_READY, 4'd1, 16'h0000);
		send_op(OP_SCHEDULE, 4'd0, 16'h0000);
		send_op(OP_SCHEDULE, 4'd0, 16'h0000);
		send_op(OP_BLOCK_ALL, 4'd0, 16'h0000);
		send_op(OP_READY, 4'd15, 16'h0000);

		for (int p = 0; p < 7; p++) begin
			write_wrap(wraps[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0)
					src_burst = ($urandom_range(0, 3) == 0);
				if (p == 1 && i == 60) begin
					src_burst = 1'b1;
					rsp_hold = 1'b1;
				end
				send_op(pick_op(), pick_id(), pick_interval());
			end
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("%0d transactions sent, %0d results checked", n_sent, sb.n_checked);
		$display("%0d dispatches, %0d idle scans, %0d error answers",
			sb.n_dispatch, sb.n_idle, sb.n_err);
		$display("tick wrap settings 1000, 50, 65535, 1, 0, %0d, with one long response hold-off",
			wraps[5]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/tdd_pkg.sv
rtl/tdd_if.sv
rtl/tdd_cell.sv
rtl/timed_task_dispatcher_core.sv
rtl/tdd_checker.sv
test/tb_top.sv
